>>> design/tmbp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the background tile pixel fetcher.
// No dependencies; every other file of the block but tmbp_if imports this package.
package tmbp_pkg;

  localparam int VMEM_AW  = 14;
  localparam int PAL_WORDS_AW = 5;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [1:0] ACT_VWRITE = 2'd0;
  localparam logic [1:0] ACT_PWRITE = 2'd1;
  localparam logic [1:0] ACT_PIXEL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_DAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  // High bits of a map-area address: 0x1800 sets bits 12 and 11
  localparam logic [1:0] MAP_AREA = 2'b11;

  typedef enum logic [1:0] {
    KIND_VWRITE = 2'd0,
    KIND_PWRITE = 2'd1,
    KIND_PIXEL  = 2'd2
  } tmbp_kind_t;

  typedef struct packed {
    tmbp_kind_t           kind;
    logic [VMEM_AW-1:0]   addr;
    logic [7:0]           data;
    logic [7:0]           x;
    logic [7:0]           y;
  } tmbp_entry_t;

  typedef struct packed {
    logic map_select;
    logic unsigned_tile_data;
    logic color_mode;
  } tmbp_cfg_t;

  // Expand a 5-bit channel to 8 bits by replicating its top bits
  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

>>> design/tmbp_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces for request items and pixel results.
// Widths follow the field list of tmbp_pkg; no other dependencies.
interface tmbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [13:0] mem_addr;
  logic [7:0] mem_data;
  logic [7:0] pix_x;
  logic [7:0] pix_y;

  modport source (output valid, action, mem_addr, mem_data, pix_x, pix_y, input ready);
  modport sink   (input valid, action, mem_addr, mem_data, pix_x, pix_y, output ready);
endinterface

interface tmbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] color_index;

  modport source (output valid, red, green, blue, color_index, input ready);
  modport sink   (input valid, red, green, blue, color_index, output ready);
endinterface

>>> design/tmbp_front.sv
`timescale 1ns / 1ps
// Front end: accepts request items, classifies the action, drops unused codes.
// Depends on tmbp_pkg and tmbp_if; feeds tmbp_queue.
module tmbp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  tmbp_in_if.sink              in_ch,
  output logic                 push_valid,
  output tmbp_pkg::tmbp_entry_t push_entry,
  input  logic                 push_ready
);
  import tmbp_pkg::*;

  logic        hold_valid_r, hold_valid_nxt;
  tmbp_entry_t hold_entry_r;
  tmbp_entry_t cls_entry;
  logic        keep;
  logic        accept;
  logic        push;

  assign push       = hold_valid_r && push_ready;
  assign in_ch.ready = !hold_valid_r || push_ready;
  assign accept     = in_ch.valid && in_ch.ready;

  always_comb begin
    cls_entry.addr = in_ch.mem_addr;
    cls_entry.data = in_ch.mem_data;
    cls_entry.x    = in_ch.pix_x;
    cls_entry.y    = in_ch.pix_y;
    cls_entry.kind = KIND_VWRITE;
    keep           = 1'b1;
    unique case (in_ch.action)
      ACT_VWRITE: cls_entry.kind = KIND_VWRITE;
      ACT_PWRITE: cls_entry.kind = KIND_PWRITE;
      ACT_PIXEL:  cls_entry.kind = KIND_PIXEL;
      default:    keep = 1'b0;  // unused action: accept and drop
    endcase
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept && keep) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      hold_entry_r <= cls_entry;
    end
  end

  assign push_valid = hold_valid_r;
  assign push_entry = hold_entry_r;

endmodule

>>> design/tmbp_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified items between the front end and the executor.
// Depends on tmbp_pkg for the entry type and depth.
module tmbp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  tmbp_pkg::tmbp_entry_t push_entry,
  output logic                  push_ready,
  output logic                  pop_valid,
  output tmbp_pkg::tmbp_entry_t pop_entry,
  input  logic                  pop_ready
);
  import tmbp_pkg::*;

  tmbp_entry_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> design/tmbp_back.sv
`timescale 1ns / 1ps
// Executor: owns video and palette memories, runs writes and pixel fetches.
// Depends on tmbp_pkg and tmbp_if; drains tmbp_queue.
module tmbp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tmbp_pkg::tmbp_cfg_t   cfg,
  input  logic                  q_valid,
  input  tmbp_pkg::tmbp_entry_t q_head,
  output logic                  q_pop,
  tmbp_out_if.source            out_ch
);
  import tmbp_pkg::*;

  typedef enum logic [5:0] {
    ST_DISP = 6'b000001,
    ST_ATTR = 6'b000010,
    ST_LO   = 6'b000100,
    ST_HI   = 6'b001000,
    ST_PAL  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Memories: single port video memory, palette as 16-bit words with byte lanes
  logic [7:0]  vmem [2**VMEM_AW];
  logic [15:0] pmem [2**PAL_WORDS_AW];
  logic [7:0]  vrd_r;
  logic [15:0] prd_r;

  logic               vwe, vre;
  logic [VMEM_AW-1:0] vaddr;
  logic               pwe, pre;
  logic [PAL_WORDS_AW-1:0] praddr;

  // Per-pixel working registers
  logic [9:0]  mofs_r;
  logic [2:0]  xl_r, yl_r;
  logic [7:0]  tile_r;
  logic [7:0]  lo_r;
  logic [12:0] base_r;
  logic [2:0]  sel_r;
  logic [2:0]  palnum_r;
  logic [1:0]  cidx_r;

  logic [7:0]  tile_now, attr_now;
  logic [2:0]  row_now, sel_now;
  logic [12:0] base_now;
  logic [1:0]  color_now;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  red_r, green_r, blue_r;
  logic [1:0]  cout_r;
  logic        out_load, out_free, dispatch_ok;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == ST_OUT) && out_free;
  assign dispatch_ok = (state_r == ST_DISP) || out_load;

  always_comb begin
    tile_now  = cfg.color_mode ? tile_r : vrd_r;
    attr_now  = cfg.color_mode ? vrd_r : 8'h00;
    row_now   = yl_r ^ {3{attr_now[6]}};
    sel_now   = attr_now[5] ? xl_r : ~xl_r;
    base_now  = {attr_now[3], ~cfg.unsigned_tile_data & ~tile_now[7], tile_now, row_now};
    color_now = {vrd_r[sel_r], lo_r[sel_r]};
  end

  always_comb begin
    state_nxt = state_r;
    vwe       = 1'b0;
    vre       = 1'b0;
    vaddr     = q_head.addr;
    pwe       = 1'b0;
    pre       = 1'b0;
    praddr    = {palnum_r, color_now};
    q_pop     = 1'b0;
    unique case (state_r)
      ST_DISP: state_nxt = ST_DISP;
      ST_ATTR: begin
        vre       = 1'b1;
        vaddr     = {1'b1, MAP_AREA, cfg.map_select, mofs_r};
        state_nxt = ST_LO;
      end
      ST_LO: begin
        vre       = 1'b1;
        vaddr     = {base_now, 1'b0};
        state_nxt = ST_HI;
      end
      ST_HI: begin
        vre       = 1'b1;
        vaddr     = {base_r, 1'b1};
        state_nxt = ST_PAL;
      end
      ST_PAL: begin
        pre       = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_DISP;
        end
      end
      default: state_nxt = ST_DISP;
    endcase
    // Dispatch the queue head; the memory port is free in both states
    if (dispatch_ok && q_valid) begin
      q_pop = 1'b1;
      unique case (q_head.kind)
        KIND_VWRITE: vwe = 1'b1;
        KIND_PWRITE: pwe = 1'b1;
        KIND_PIXEL: begin
          vre       = 1'b1;
          vaddr     = {1'b0, MAP_AREA, cfg.map_select, q_head.y[7:3], q_head.x[7:3]};
          state_nxt = cfg.color_mode ? ST_ATTR : ST_LO;
        end
        default: q_pop = 1'b1;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DISP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vaddr] <= q_head.data;
    end
    if (vre) begin
      vrd_r <= vmem[vaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pwe && !q_head.addr[0]) begin
      pmem[q_head.addr[5:1]][7:0] <= q_head.data;
    end
    if (pwe && q_head.addr[0]) begin
      pmem[q_head.addr[5:1]][15:8] <= q_head.data;
    end
    if (pre) begin
      prd_r <= pmem[praddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dispatch_ok && q_valid && q_head.kind == KIND_PIXEL) begin
      mofs_r <= {q_head.y[7:3], q_head.x[7:3]};
      xl_r   <= q_head.x[2:0];
      yl_r   <= q_head.y[2:0];
    end
    if (state_r == ST_ATTR) begin
      tile_r <= vrd_r;
    end
    if (state_r == ST_LO) begin
      base_r   <= base_now;
      sel_r    <= sel_now;
      palnum_r <= attr_now[2:0];
    end
    if (state_r == ST_HI) begin
      lo_r <= vrd_r;
    end
    if (state_r == ST_PAL) begin
      cidx_r <= color_now;
    end
    if (out_load) begin
      red_r   <= expand5(prd_r[4:0]);
      green_r <= expand5(prd_r[9:5]);
      blue_r  <= expand5(prd_r[14:10]);
      cout_r  <= cidx_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red         = red_r;
  assign out_ch.green       = green_r;
  assign out_ch.blue        = blue_r;
  assign out_ch.color_index = cout_r;

  a_pal_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PAL |=> state_r == ST_OUT)
    else $error("palette read not followed by output stage");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && !out_ch.ready) |=> state_r == ST_OUT)
    else $error("pixel left output stage while result stalled");

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output stage");

  a_port_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(vwe && vre))
    else $error("video memory read and write in one cycle");

endmodule

>>> design/tile_map_background_pixel.sv
`timescale 1ns / 1ps
// Top level of the background tile pixel fetcher: config registers and wiring.
// Depends on tmbp_pkg, tmbp_if, tmbp_front, tmbp_queue and tmbp_back.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+---------------------------------------
//  in_ch    | in        | valid/ready      | action, mem_addr, mem_data, pix_x, pix_y
//  out_ch   | out       | valid/ready      | red, green, blue, color_index
//  cfg_*    | in        | cfg_we, no wait  | cfg_index, cfg_data
//
// A memory write is done as it is dispatched and needs no fetch states. A pixel
// request reads, through the single video memory port, the map byte, the
// attribute byte in colour mode only, low plane, high plane, then a palette word.
// On its way to out_ch.valid a request passes the front hold register, the
// queue slot, then the fetch states.
// Reset clears control state only; both memories are undefined until written.
// A stalled result holds the executor; the front end and queue keep taking
// requests until the four-entry queue and the front hold register fill.
module tile_map_background_pixel (
  input  logic                            clk,
  input  logic                            rst_n,
  tmbp_in_if.sink                         in_ch,
  tmbp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tmbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmbp_pkg::*;

  tmbp_cfg_t   cfg_r, cfg_nxt;
  logic        push_valid, push_ready;
  tmbp_entry_t push_entry;
  logic        q_valid, q_pop;
  tmbp_entry_t q_head;

  // Decode config writes; an index past the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_SELECT:   cfg_nxt.map_select         = cfg_data[0];
        CFG_UNSIGNED_DAT: cfg_nxt.unsigned_tile_data = cfg_data[0];
        CFG_COLOR_MODE:   cfg_nxt.color_mode         = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify and hold incoming requests
  tmbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decouple front end from executor
  tmbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_entry  (q_head),
    .pop_ready  (q_pop)
  );

  // Execute writes and pixel fetches in order
  tmbp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
